// File: rtl/ascii_number_size_parser_defines.svh
// Assertion helpers shared by the RTL files.
`ifndef ASCII_NUMBER_SIZE_PARSER_DEFINES_SVH
`define ASCII_NUMBER_SIZE_PARSER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ASNP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASNP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/asnp_pkg.sv
`default_nettype none

package asnp_pkg;

   localparam int CHAR_W  = 8;
   localparam int VALUE_W = 32;
   localparam int BASE_W  = 5;
   localparam int NIB_W   = 4;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Classified character as it travels from front end to back end.
   typedef struct packed {
      logic               term;     // zero byte
      logic               minus;    // '-'
      logic               digit;    // '0'..'9'
      logic               xchar;    // 'x' or 'X'
      logic               hexl;     // 'a'..'f' or 'A'..'F'
      logic               mchar;    // 'M'
      logic               kchar;    // 'K'
      logic               upper_b;  // 'B'
      logic               lower_b;  // 'b'
      logic [NIB_W-1:0]   nib;      // digit value for digit / hexl
   } class_type;

   localparam int CLASS_W = $bits(class_type);

endpackage

`default_nettype wire

// File: rtl/asnp_req_if.sv
`default_nettype none

interface asnp_req_if;
   logic                        valid;
   logic                        ready;
   logic [asnp_pkg::CHAR_W-1:0] character;

   modport source (output valid, output character, input ready);
   modport sink   (input valid, input character, output ready);
endinterface

`default_nettype wire

// File: rtl/asnp_rsp_if.sv
`default_nettype none

interface asnp_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [asnp_pkg::VALUE_W-1:0] value;
   logic                                parse_error;

   modport source (output valid, output value, output parse_error, input ready);
   modport sink   (input valid, input value, input parse_error, output ready);
endinterface

`default_nettype wire

// File: rtl/ascii_number_size_parser.sv
// ascii_number_size_parser: ASCII string to signed 32-bit integer with size suffix.
// req channel: one character word per handshake (valid && ready). A zero byte ends
//   the string; every other word only updates the parse state.
// rsp channel: one word per string: value (two's complement, wraps) and
//   parse_error. Sent when the zero byte has been worked off.
// csr port: csr_wr_en / csr_wr_data write the default base (0 = decimal with
//   automatic switch to hex). Write only while idle; a write before the first
//   character of a string takes effect for that string.
// Throughput: one character per cycle while no terminator waits on rsp. Front end
//   registers the classified character, a 2-word queue feeds the back end, which
//   does one multiply-add (accumulator times base) per digit or hex letter.
// Result path: front-end register, queue, then the back end's result register.
// Stall: while rsp is held off the back end keeps parsing characters; only a
//   second terminator waits, then the queue fills and req.ready drops.
// Reset: synchronous, clears the queue and the rsp valid flag, loads default base 0.
`default_nettype none

module ascii_number_size_parser (
   input  wire logic                        clock,
   input  wire logic                        reset,
   asnp_req_if.sink                         req,
   asnp_rsp_if.source                       rsp,
   input  wire logic                        csr_wr_en,
   input  wire logic [asnp_pkg::BASE_W-1:0] csr_wr_data
);

   // front end -> queue
   logic                fe_valid;
   asnp_pkg::class_type fe_word;
   logic                fe_ready;

   // queue -> back end
   logic                q_valid;
   asnp_pkg::class_type q_word;
   logic                q_ready;

   asnp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .out_valid (fe_valid),
      .out_word  (fe_word),
      .out_ready (fe_ready)
   );

   asnp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fe_valid),
      .in_word   (fe_word),
      .in_ready  (fe_ready),
      .out_valid (q_valid),
      .out_word  (q_word),
      .out_ready (q_ready)
   );

   // back end owns the base register and the result register
   asnp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (q_valid),
      .in_word     (q_word),
      .in_ready    (q_ready),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp         (rsp)
   );

endmodule

`default_nettype wire

// File: rtl/asnp_front.sv
`default_nettype none

// Accepts characters and registers their classification.
module asnp_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   asnp_req_if.sink                  req,
   output logic                      out_valid,
   output asnp_pkg::class_type       out_word,
   input  wire logic                 out_ready
);

   localparam logic [asnp_pkg::CHAR_W-1:0] CH_NUL   = 8'h00;
   localparam logic [asnp_pkg::CHAR_W-1:0] CH_MINUS = 8'h2d;
   localparam logic [asnp_pkg::CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [asnp_pkg::CHAR_W-1:0] CH_NINE  = 8'h39;
   localparam logic [asnp_pkg::CHAR_W-1:0] CH_LA    = 8'h61;
   localparam logic [asnp_pkg::CHAR_W-1:0] CH_LF    = 8'h66;
   localparam logic [asnp_pkg::CHAR_W-1:0] CH_LX    = 8'h78;
   localparam logic [asnp_pkg::CHAR_W-1:0] CH_UM    = 8'h4d;
   localparam logic [asnp_pkg::CHAR_W-1:0] CH_UK    = 8'h4b;
   localparam logic [asnp_pkg::CHAR_W-1:0] CH_UB    = 8'h42;
   localparam logic [asnp_pkg::CHAR_W-1:0] CH_LB    = 8'h62;
   localparam logic [asnp_pkg::CHAR_W-1:0] CASE_BIT = 8'h20;
   localparam logic [asnp_pkg::CHAR_W-1:0] HEX_OFS  = 8'h57; // 'a' - 10

   logic                      valid_ff, valid_in;
   asnp_pkg::class_type       word_ff, word_in;
   logic [asnp_pkg::CHAR_W-1:0] lc;
   logic [asnp_pkg::CHAR_W-1:0] dig_val;
   logic [asnp_pkg::CHAR_W-1:0] hex_val;
   logic                      accept;

   assign req.ready = !valid_ff || out_ready;
   assign accept    = req.valid && req.ready;

   always_comb begin
      lc      = req.character | CASE_BIT;
      dig_val = req.character - CH_ZERO;
      hex_val = lc - HEX_OFS;
      word_in.term    = (req.character == CH_NUL);
      word_in.minus   = (req.character == CH_MINUS);
      word_in.digit   = (req.character >= CH_ZERO) && (req.character <= CH_NINE);
      word_in.xchar   = (lc == CH_LX);
      word_in.hexl    = (lc >= CH_LA) && (lc <= CH_LF);
      word_in.mchar   = (req.character == CH_UM);
      word_in.kchar   = (req.character == CH_UK);
      word_in.upper_b = (req.character == CH_UB);
      word_in.lower_b = (req.character == CH_LB);
      word_in.nib     = word_in.digit ? dig_val[asnp_pkg::NIB_W-1:0]
                                      : hex_val[asnp_pkg::NIB_W-1:0];
   end

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

`default_nettype wire

// File: rtl/asnp_queue.sv
`default_nettype none
`include "ascii_number_size_parser_defines.svh"

// Short FIFO of classified words between front end and back end.
module asnp_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  wire asnp_pkg::class_type  in_word,
   output logic                      in_ready,
   output logic                      out_valid,
   output asnp_pkg::class_type       out_word,
   input  wire logic                 out_ready
);

   localparam logic [asnp_pkg::QUEUE_PTR_W-1:0] PTR_LAST =
      asnp_pkg::QUEUE_PTR_W'(asnp_pkg::QUEUE_DEPTH - 1);
   localparam logic [asnp_pkg::QUEUE_CNT_W-1:0] CNT_FULL =
      asnp_pkg::QUEUE_CNT_W'(asnp_pkg::QUEUE_DEPTH);

   asnp_pkg::class_type                 slot_ff [asnp_pkg::QUEUE_DEPTH];
   logic [asnp_pkg::QUEUE_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [asnp_pkg::QUEUE_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [asnp_pkg::QUEUE_CNT_W-1:0]    count_ff, count_in;
   logic                                push, pop;

   assign in_ready  = (count_ff != CNT_FULL);
   assign out_valid = (count_ff != '0);
   assign out_word  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_word;
      end
   end

   `ASNP_ASSERT_NOW(a_queue_count_bound, clock, reset, 1'b1,
      count_ff <= CNT_FULL, "queue overfill")
   `ASNP_ASSERT_NEXT(a_queue_full_holds, clock, reset, count_ff == CNT_FULL && !out_ready,
      count_ff == CNT_FULL, "queue lost a word")

endmodule

`default_nettype wire

// File: rtl/asnp_back.sv
`default_nettype none
`include "ascii_number_size_parser_defines.svh"

// Parse state machine, default base register and result register.
module asnp_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        in_valid,
   input  wire asnp_pkg::class_type         in_word,
   output logic                             in_ready,
   input  wire logic                        csr_wr_en,
   input  wire logic [asnp_pkg::BASE_W-1:0] csr_wr_data,
   asnp_rsp_if.source                       rsp
);

   localparam int VW = asnp_pkg::VALUE_W;
   localparam int BW = asnp_pkg::BASE_W;

   localparam logic [2:0] PH_DIGITS   = 3'd0;
   localparam logic [2:0] PH_SUF_M    = 3'd1;
   localparam logic [2:0] PH_SUF_K    = 3'd2;
   localparam logic [2:0] PH_SUF_DONE = 3'd3;
   localparam logic [2:0] PH_ERROR    = 3'd4;

   localparam logic [1:0] SC_MB = 2'd0;
   localparam logic [1:0] SC_KB = 2'd1;
   localparam logic [1:0] SC_MBIT = 2'd2;
   localparam logic [1:0] SC_KBIT = 2'd3;

   localparam logic [BW-1:0] BASE_DEC = BW'(10);
   localparam logic [BW-1:0] BASE_HEX = BW'(16);

   logic [VW-1:0] acc_ff, acc_in;
   logic [VW-1:0] hex_ff, hex_in;
   logic [BW-1:0] base_ff, base_in;
   logic [BW-1:0] dbase_ff, dbase_in;
   logic          auto_ff, auto_in;
   logic          neg_ff, neg_in;
   logic [1:0]    pos_ff, pos_in;
   logic          lz_ff, lz_in;
   logic [2:0]    phase_ff, phase_in;
   logic [1:0]    scale_ff, scale_in;
   logic          err_ff, err_in;
   logic          sempty_ff, sempty_in;
   logic          fresh_ff, fresh_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0] rsp_value_ff, rsp_value_in;
   logic          rsp_err_ff, rsp_err_in;

   logic          out_free;
   logic          pop;
   logic [VW-1:0] prod;
   logic [VW-1:0] letter_src;
   logic [VW-1:0] nib_ext;
   logic [VW-1:0] scaled_src;
   logic [VW-1:0] result_mag;
   logic          result_err;
   logic [BW-1:0] start_base;
   logic [BW-1:0] cfg_start_base;

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign in_ready = !in_word.term || out_free;
   assign pop      = in_valid && in_ready;

   assign prod       = acc_ff * VW'(base_ff);
   assign nib_ext    = VW'(in_word.nib);
   assign letter_src = (base_ff != BASE_HEX) ? hex_ff : acc_ff;
   assign scaled_src = sempty_ff ? VW'(1) : acc_ff;
   assign start_base     = (dbase_ff == '0) ? BASE_DEC : dbase_ff;
   assign cfg_start_base = (csr_wr_data == '0) ? BASE_DEC : csr_wr_data;

   // Result of the terminator: scale is a fixed shift per suffix
   always_comb begin
      result_mag = acc_ff;
      result_err = err_ff;
      if (phase_ff == PH_SUF_DONE) begin
         case (scale_ff)
            SC_MB:   result_mag = scaled_src << 20;
            SC_KB:   result_mag = scaled_src << 10;
            SC_MBIT: result_mag = scaled_src << 17;
            default: result_mag = scaled_src << 7;
         endcase
      end else if ((phase_ff == PH_SUF_M) || (phase_ff == PH_SUF_K)) begin
         result_err = 1'b1;
      end
   end

   always_comb begin
      acc_in    = acc_ff;
      hex_in    = hex_ff;
      base_in   = base_ff;
      dbase_in  = dbase_ff;
      auto_in   = auto_ff;
      neg_in    = neg_ff;
      pos_in    = pos_ff;
      lz_in     = lz_ff;
      phase_in  = phase_ff;
      scale_in  = scale_ff;
      err_in    = err_ff;
      sempty_in = sempty_ff;
      fresh_in  = fresh_ff;

      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_value_in = rsp_value_ff;
      rsp_err_in   = rsp_err_ff;

      if (pop && in_word.term) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = neg_ff ? (VW'(0) - result_mag) : result_mag;
         rsp_err_in   = result_err;
         // reload for the next string
         acc_in    = '0;
         hex_in    = '0;
         pos_in    = '0;
         lz_in     = 1'b0;
         base_in   = start_base;
         auto_in   = (dbase_ff == '0);
         neg_in    = 1'b0;
         phase_in  = PH_DIGITS;
         scale_in  = '0;
         err_in    = 1'b0;
         sempty_in = 1'b0;
         fresh_in  = 1'b1;
      end else if (pop) begin
         fresh_in = 1'b0;
         unique case (phase_ff)
            PH_DIGITS: begin
               if ((pos_ff == 2'd0) && in_word.minus) begin
                  neg_in  = !neg_ff;
                  auto_in = 1'b0;
                  acc_in  = '0;
                  hex_in  = '0;
                  pos_in  = '0;
                  lz_in   = 1'b0;
               end else if (in_word.digit) begin
                  acc_in = prod + nib_ext;
                  hex_in = {hex_ff[VW-5:0], 4'b0000} + nib_ext;
                  lz_in  = (pos_ff == 2'd0) && (in_word.nib == '0);
                  pos_in = (pos_ff == 2'd2) ? pos_ff : pos_ff + 2'd1;
               end else if ((pos_ff == 2'd1) && in_word.xchar && lz_ff) begin
                  base_in = BASE_HEX;
                  auto_in = 1'b0;
                  acc_in  = '0;
                  hex_in  = '0;
                  pos_in  = '0;
                  lz_in   = 1'b0;
               end else if (in_word.hexl) begin
                  if ((base_ff != BASE_HEX) && !auto_ff) begin
                     phase_in = PH_ERROR;
                     err_in   = 1'b1;
                  end else begin
                     // hex base, or auto mode re-reading the digits so far as hex
                     base_in = BASE_HEX;
                     auto_in = auto_ff && (base_ff == BASE_HEX);
                     acc_in  = {letter_src[VW-5:0], 4'b0000} + nib_ext;
                     lz_in   = 1'b0;
                     pos_in  = (pos_ff == 2'd2) ? pos_ff : pos_ff + 2'd1;
                  end
               end else if (in_word.mchar || in_word.kchar) begin
                  sempty_in = (pos_ff == 2'd0);
                  phase_in  = in_word.mchar ? PH_SUF_M : PH_SUF_K;
               end else begin
                  phase_in = PH_ERROR;
                  err_in   = 1'b1;
               end
            end
            PH_SUF_M, PH_SUF_K: begin
               if (in_word.upper_b) begin
                  scale_in = (phase_ff == PH_SUF_M) ? SC_MB : SC_KB;
                  phase_in = PH_SUF_DONE;
               end else if (in_word.lower_b) begin
                  scale_in = (phase_ff == PH_SUF_M) ? SC_MBIT : SC_KBIT;
                  phase_in = PH_SUF_DONE;
               end else begin
                  phase_in = PH_ERROR;
                  err_in   = 1'b1;
               end
            end
            PH_SUF_DONE: begin
               phase_in = PH_ERROR;
               err_in   = 1'b1;
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end

      // base register; a fresh string picks it up at once
      if (csr_wr_en) begin
         dbase_in = csr_wr_data;
         if (fresh_ff) begin
            base_in = cfg_start_base;
            auto_in = (csr_wr_data == '0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         hex_ff       <= '0;
         base_ff      <= BASE_DEC;
         dbase_ff     <= '0;
         auto_ff      <= 1'b1;
         neg_ff       <= 1'b0;
         pos_ff       <= '0;
         lz_ff        <= 1'b0;
         phase_ff     <= PH_DIGITS;
         scale_ff     <= '0;
         err_ff       <= 1'b0;
         sempty_ff    <= 1'b0;
         fresh_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         hex_ff       <= hex_in;
         base_ff      <= base_in;
         dbase_ff     <= dbase_in;
         auto_ff      <= auto_in;
         neg_ff       <= neg_in;
         pos_ff       <= pos_in;
         lz_ff        <= lz_in;
         phase_ff     <= phase_in;
         scale_ff     <= scale_in;
         err_ff       <= err_in;
         sempty_ff    <= sempty_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.value       = rsp_value_ff;
   assign rsp.parse_error = rsp_err_ff;

   `ASNP_ASSERT_NOW(a_error_phase_flag, clock, reset, phase_ff == PH_ERROR,
      err_ff, "error phase without error flag")
   `ASNP_ASSERT_NEXT(a_term_restarts, clock, reset, pop && in_word.term,
      phase_ff == PH_DIGITS && !err_ff && fresh_ff && rsp_valid_ff,
      "terminator did not restart")
   `ASNP_ASSERT_NOW(a_term_needs_slot, clock, reset, pop && in_word.term,
      out_free, "result overwritten")
   `ASNP_ASSERT_NOW(a_pos_range, clock, reset, 1'b1,
      pos_ff != 2'd3, "substring position out of range")

endmodule

`default_nettype wire

// File: verif/ascii_number_size_parser_tb.sv
`default_nettype none

module ascii_number_size_parser_tb;

   // ------------------------------------------------------------------
   // Constants
   // ------------------------------------------------------------------
   localparam int CHAR_W  = asnp_pkg::CHAR_W;
   localparam int VALUE_W = asnp_pkg::VALUE_W;
   localparam int BASE_W  = asnp_pkg::BASE_W;

   localparam int HALF_PERIOD     = 10;
   localparam int RESET_CYCLES    = 5;
   localparam int PHASE_CHARS     = 110;     // chars per base setting in the random part
   localparam int HOLD_OFF_CYCLES = 300;     // long rsp hold-off to back up the block
   localparam int SETTLE_CYCLES   = 8;       // covers the result path plus queue slack
   localparam int DRAIN_LIMIT     = 2000;    // cycles allowed for the last results
   localparam int RUN_LIMIT       = 4000000; // time units, far above the slowest run

   localparam logic [CHAR_W-1:0] TERMINATOR = 8'h00;
   localparam logic [CHAR_W-1:0] TOP_BYTE   = 8'hFF;

   // size suffix selectors, as the predictor keeps them
   localparam logic [1:0] SCALE_MB   = 2'd0;
   localparam logic [1:0] SCALE_KB   = 2'd1;
   localparam logic [1:0] SCALE_MBIT = 2'd2;
   localparam logic [1:0] SCALE_KBIT = 2'd3;

   // where the parse of the current string stands
   typedef enum logic [2:0] {
      SCAN_DIGITS,
      SCAN_MEGA,    // 'M' seen, waiting for B or b
      SCAN_KILO,    // 'K' seen, waiting for B or b
      SCAN_SCALED,  // full suffix seen, only the terminator may follow
      SCAN_FROZEN   // bad character, rest of string ignored
   } scan_phase_type;

   // receiver stall patterns
   typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HALF, RX_SLOW} rx_mode_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      parse_error;
   } parse_result_type;

   // ------------------------------------------------------------------
   // Clock, reset, interfaces, DUT
   // ------------------------------------------------------------------
   logic              clock = 1'b0;
   logic              reset;
   logic              csr_wr_en;
   logic [BASE_W-1:0] csr_wr_data;

   asnp_req_if req_if();
   asnp_rsp_if rsp_if();

   always #HALF_PERIOD clock = ~clock;

   ascii_number_size_parser dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .rsp         (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // ------------------------------------------------------------------
   // Shared testbench state
   // ------------------------------------------------------------------
   logic [CHAR_W-1:0] pending_chars[$];     // words still to be offered on req
   parse_result_type  expected_results[$];  // predicted rsp words, oldest first

   int   mismatch_count   = 0;
   int   strings_parsed   = 0;  // terminators accepted
   int   results_seen     = 0;
   int   chars_accepted   = 0;
   int   input_stalls     = 0;  // cycles with req valid but not ready
   int   base_settings    = 0;
   logic random_phase_on  = 1'b0;
   logic hold_off         = 1'b0;
   logic char_fire        = 1'b0;  // req handshake seen at the last rising edge

   // ------------------------------------------------------------------
   // Parse predictor: mirrors the block's string state
   // ------------------------------------------------------------------
   logic [BASE_W-1:0]  base_reg;    // predicted default base register
   logic [VALUE_W-1:0] dec_acc;     // value in the active base
   logic [VALUE_W-1:0] hex_acc;     // same digits read as hex, for the auto switch
   logic [BASE_W-1:0]  cur_base;
   logic               auto_hex;
   logic               negate;
   logic [1:0]         sub_pos;     // 0, 1, or 2+ characters into the substring
   logic               lead_zero;
   logic [1:0]         scale_sel;
   logic               err_seen;
   logic               empty_num;   // suffix with no digits in front means 1
   logic               fresh;       // no char of this string taken yet
   scan_phase_type     scan_phase;

   task automatic clear_number();
      dec_acc   = '0;
      hex_acc   = '0;
      sub_pos   = 2'd0;
      lead_zero = 1'b0;
   endtask

   task automatic restart_string();
      clear_number();
      cur_base   = (base_reg == 0) ? BASE_W'(10) : base_reg;
      auto_hex   = (base_reg == 0);
      negate     = 1'b0;
      scan_phase = SCAN_DIGITS;
      scale_sel  = SCALE_MB;
      err_seen   = 1'b0;
      empty_num  = 1'b0;
      fresh      = 1'b1;
   endtask

   task automatic freeze_value();
      scan_phase = SCAN_FROZEN;
      err_seen   = 1'b1;
   endtask

   task automatic count_digit(input logic [CHAR_W-1:0] c);
      lead_zero = (sub_pos == 0) && (c == "0");
      if (sub_pos < 2) sub_pos = sub_pos + 2'd1;
   endtask

   task automatic parse_char(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0]  lc;
      logic [VALUE_W-1:0] v;
      logic               e;
      lc = c | 8'h20;
      if (c != TERMINATOR) begin
         fresh = 1'b0;
         case (scan_phase)
            SCAN_DIGITS: begin
               if (sub_pos == 0 && c == "-") begin
                  // leading minus of a substring: flip sign, lock the base
                  negate   = !negate;
                  auto_hex = 1'b0;
                  clear_number();
               end else if (c >= "0" && c <= "9") begin
                  dec_acc = dec_acc * cur_base + (c - "0");
                  hex_acc = hex_acc * 16 + (c - "0");
                  count_digit(c);
               end else if (sub_pos == 1 && lc == "x" && lead_zero) begin
                  cur_base = BASE_W'(16);
                  auto_hex = 1'b0;
                  clear_number();
               end else if (lc >= "a" && lc <= "f") begin
                  if (cur_base != 16 && !auto_hex) begin
                     freeze_value();
                  end else begin
                     if (cur_base != 16) begin
                        // auto mode: re-read what came so far as hex
                        dec_acc  = hex_acc;
                        cur_base = BASE_W'(16);
                        auto_hex = 1'b0;
                     end
                     dec_acc = dec_acc * 16 + (lc - "a" + 10);
                     count_digit(c);
                  end
               end else if (c == "M" || c == "K") begin
                  empty_num  = (sub_pos == 0);
                  scan_phase = (c == "M") ? SCAN_MEGA : SCAN_KILO;
               end else begin
                  freeze_value();
               end
            end
            SCAN_MEGA, SCAN_KILO: begin
               if (c == "B") begin
                  scale_sel  = (scan_phase == SCAN_MEGA) ? SCALE_MB : SCALE_KB;
                  scan_phase = SCAN_SCALED;
               end else if (c == "b") begin
                  scale_sel  = (scan_phase == SCAN_MEGA) ? SCALE_MBIT : SCALE_KBIT;
                  scan_phase = SCAN_SCALED;
               end else begin
                  freeze_value();
               end
            end
            SCAN_SCALED: freeze_value();
            default: ;
         endcase
      end else begin
         v = dec_acc;
         e = err_seen;
         if (scan_phase == SCAN_SCALED) begin
            v = empty_num ? 32'd1 : dec_acc;
            case (scale_sel)
               SCALE_MB:   v = v << 20;
               SCALE_KB:   v = v << 10;
               SCALE_MBIT: v = v << 17;
               default:    v = v << 7;
            endcase
         end else if (scan_phase == SCAN_MEGA || scan_phase == SCAN_KILO) begin
            e = 1'b1;  // suffix cut short by the terminator
         end
         if (negate) v = -v;
         expected_results.push_back('{value: v, parse_error: e});
         strings_parsed++;
         restart_string();
      end
   endtask

   // ------------------------------------------------------------------
   // Rising edge: track accepted words and register writes
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         base_reg = '0;
         restart_string();
         char_fire <= 1'b0;
      end else begin
         char_fire <= req_if.valid && req_if.ready;
         if (req_if.valid && !req_if.ready) input_stalls++;
         if (req_if.valid && req_if.ready) begin
            chars_accepted++;
            parse_char(req_if.character);
         end
         if (csr_wr_en) begin
            // a write before the first char of a string applies to that string
            base_reg = csr_wr_data;
            if (fresh) restart_string();
         end
      end
   end

   // ------------------------------------------------------------------
   // Driver: bursts of words with random gaps, changes at the falling edge
   // ------------------------------------------------------------------
   int burst_left = 0;
   int gap_left   = 0;

   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (req_if.valid && !char_fire) begin
         // word still on offer, hold it
      end else begin
         if (burst_left == 0 && gap_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
         end
         if (gap_left > 0) begin
            gap_left--;
            req_if.valid <= 1'b0;
         end else if (pending_chars.size() > 0) begin
            req_if.valid     <= 1'b1;
            req_if.character <= pending_chars.pop_front();
            if (burst_left > 0) burst_left--;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Receiver: stall pattern is redrawn at random after a random run of cycles
   // ------------------------------------------------------------------
   rx_mode_type rx_mode  = RX_OPEN;
   int          rx_timer = 0;
   logic        rx_open;

   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rx_timer == 0) begin
            rx_mode  = rx_mode_type'($urandom_range(0, 3));
            rx_timer = $urandom_range(20, 80);
         end
         rx_timer--;
         case (rx_mode)
            RX_OPEN:  rx_open = 1'b1;
            RX_LIGHT: rx_open = ($urandom_range(0, 3) != 0);
            RX_HALF:  rx_open = ($urandom_range(0, 1) == 1);
            default:  rx_open = (rx_timer % 4 == 0);
         endcase
         rsp_if.ready <= rx_open && !hold_off;
      end
   end

   // Long hold-off while a full phase is queued: the block has to back up
   // and drop req ready.
   initial begin
      while (!(random_phase_on && pending_chars.size() > 60)) @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_OFF_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   // ------------------------------------------------------------------
   // Monitor and checks
   // ------------------------------------------------------------------
   parse_result_type oldest;

   task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                  input logic [VALUE_W-1:0] want);
      $display("MISMATCH at %0t: %s got %0h expected %0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         results_seen++;
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected rsp word, value", rsp_if.value, '0);
         end else begin
            oldest = expected_results.pop_front();
            if (rsp_if.value !== oldest.value)
               report_mismatch("value", rsp_if.value, oldest.value);
            if (rsp_if.parse_error !== oldest.parse_error)
               report_mismatch("parse_error", 32'(rsp_if.parse_error),
                               32'(oldest.parse_error));
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) pending_chars.push_back(s[i]);
      pending_chars.push_back(TERMINATOR);
   endtask

   // Mostly well-formed: signs, optional 0x, digits/hex letters, optional
   // suffix; some cut-short or overlong suffixes and stray bytes.
   task automatic add_random_string();
      int                n_sign;
      int                n_dig;
      int                pick;
      logic [CHAR_W-1:0] ch;
      logic [CHAR_W-1:0] text[$];
      pick   = $urandom_range(0, 9);
      n_sign = (pick < 7) ? 0 : (pick < 9) ? 1 : 2;
      repeat (n_sign) text.push_back("-");
      if ($urandom_range(0, 5) == 0) begin
         text.push_back("0");
         text.push_back($urandom_range(0, 1) ? "x" : "X");
      end
      n_dig = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 14) : $urandom_range(0, 6);
      repeat (n_dig) begin
         if ($urandom_range(0, 9) < 7)
            ch = CHAR_W'("0" + $urandom_range(0, 9));
         else
            ch = CHAR_W'(($urandom_range(0, 1) ? "a" : "A") + $urandom_range(0, 5));
         text.push_back(ch);
      end
      pick = $urandom_range(0, 9);
      if (pick >= 6) begin
         text.push_back($urandom_range(0, 1) ? "M" : "K");
         if (pick != 8) text.push_back($urandom_range(0, 1) ? "B" : "b");
         if (pick == 9) text.push_back(CHAR_W'($urandom_range(33, 126)));
      end
      if ($urandom_range(0, 7) == 0)
         text.insert($urandom_range(0, text.size()), CHAR_W'($urandom_range(1, 255)));
      foreach (text[i]) pending_chars.push_back(text[i]);
      pending_chars.push_back(TERMINATOR);
   endtask

   // Idle = nothing left to offer and every predicted word back, then a
   // settle wait for chars that produce no result.
   task automatic wait_idle();
      while (pending_chars.size() != 0 || req_if.valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_base(input logic [BASE_W-1:0] b);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= b;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      base_settings++;
   endtask

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------
   // negative entry: pick a random base for that phase
   int phase_bases[$] = '{0, 16, 10, 8, 2, 1, 31, 17, 0, 16, -1};

   initial begin
      int                drain;
      logic [BASE_W-1:0] base_pick;
      reset            = 1'b1;
      csr_wr_en        = 1'b0;
      csr_wr_data      = '0;
      req_if.valid     = 1'b0;
      req_if.character = TERMINATOR;
      rsp_if.ready     = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed, reset base (decimal with auto hex)
      push_text("");           // empty string
      push_text("--7");        // sign after sign
      push_text("0x1F");       // hex prefix
      push_text("12cMB");      // auto switch to hex, then MB
      push_text("Kb");         // suffix alone counts as 1
      pending_chars.push_back(TOP_BYTE);  // stray top byte freezes the value
      pending_chars.push_back(TERMINATOR);
      push_text("5MBx");       // overlong suffix
      push_text("K");          // suffix cut short
      wait_idle();
      write_base(BASE_W'(10));
      push_text("7a");         // hex letter with auto mode off
      wait_idle();

      // random part, one phase per base setting
      random_phase_on = 1'b1;
      foreach (phase_bases[p]) begin
         base_pick = (phase_bases[p] < 0) ? BASE_W'($urandom_range(0, 31))
                                          : BASE_W'(phase_bases[p]);
         write_base(base_pick);
         while (pending_chars.size() < PHASE_CHARS) add_random_string();
         if (p == 3) begin
            // leave a string open: next write must only apply from the next one
            pending_chars.push_back("1");
            pending_chars.push_back("2");
         end
         wait_idle();
      end

      // final drain, bounded
      drain = 0;
      while (expected_results.size() != 0 && drain < DRAIN_LIMIT) begin
         @(posedge clock);
         drain++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      while (expected_results.size() != 0) begin
         oldest = expected_results.pop_front();
         report_mismatch("missing rsp word, value", '0, oldest.value);
      end

      $display("Run covered %0d strings from %0d chars across %0d base writes",
               strings_parsed, chars_accepted, base_settings);
      $display("rsp words checked: %0d, cycles with req held off: %0d",
               results_seen, input_stalls);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // watchdog
   initial begin
      #RUN_LIMIT;
      $display("Timeout: run did not complete");
      $display("Mismatches found");
      $finish;
   end

endmodule

`default_nettype wire
